[rtl/jsc_pkg.sv]
// Package: shared types, codes and helpers of the JSON string codec.
package jsc_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNC     = 3'd1,
    ERR_BAD_ESC   = 3'd2,
    ERR_BAD_SURR  = 3'd3,
    ERR_BAD_ENC   = 3'd4,
    ERR_CTRL      = 3'd5
  } err_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ESC  = 4'd1,
    PH_HEX0 = 4'd2,
    PH_HEX1 = 4'd3,
    PH_HEX2 = 4'd4,
    PH_HEX3 = 4'd5,
    PH_SBS  = 4'd6,
    PH_SU   = 4'd7,
    PH_SHX0 = 4'd8,
    PH_SHX1 = 4'd9,
    PH_SHX2 = 4'd10,
    PH_SHX3 = 4'd11,
    PH_UTF  = 4'd12
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic [2:0] error;
  } out_word_t;

  // One classified input word: up to four bytes, or one error code.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
    logic [2:0]      error;
  } job_t;

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h41 + 8'd10);
    else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h61 + 8'd10);
    return r;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    if (b < 8'h80) r = 3'd1;
    else if (b < 8'hC0) r = 3'd0;
    else if (b < 8'hE0) r = 3'd2;
    else if (b < 8'hF0) r = 3'd3;
    else if (b < 8'hF5) r = 3'd4;
    else r = 3'd0;
    return r;
  endfunction

endpackage

[rtl/jsc_front.sv]
// Front end: parses input words, keeps the escape and UTF-8 state, emits jobs.
module jsc_front import jsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     mode_i,
  input  logic     clear_i,
  input  in_word_t in_i,
  input  logic     in_fire_i,
  output job_t     job_o,
  output logic     job_push_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [9:0]  high_q, high_d;
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  need_q, need_d;
  logic        drop_q, drop_d;

  // Next-state and job logic.
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  h;
    logic [15:0] acc;
    logic [20:0] cp;
    logic [2:0]  err, len, idx;
    logic        ok, emit_cp;
    b = in_i.in_byte;
    h = hex_val(b);
    acc = {hex_q[11:0], h[3:0]};
    cp = 21'(acc);
    err = ERR_NONE;
    emit_cp = 1'b0;
    len = lead_len(pend_q[0]);
    idx = len - {1'b0, need_q};
    ok = 1'b0;
    phase_d = phase_q;
    hex_d = hex_q;
    high_d = high_q;
    pend_d = pend_q;
    need_d = need_q;
    drop_d = drop_q;
    job_o = '0;
    job_o.last = in_i.in_last;
    job_push_o = 1'b0;

    if (in_fire_i && drop_q) begin
      if (in_i.in_last) begin
        drop_d = 1'b0;
        phase_d = PH_IDLE;
        need_d = '0;
      end
    end else if (in_fire_i) begin
      if (phase_q == PH_UTF) begin
        phase_d = PH_IDLE;
        if (len < 3'd2 || need_q == 2'd0 || {1'b0, need_q} >= len) begin
          err = ERR_BAD_ENC;
        end else begin
          if (idx == 3'd1 && pend_q[0] == 8'hE0) ok = b >= 8'hA0 && b <= 8'hBF;
          else if (idx == 3'd1 && pend_q[0] == 8'hF0) ok = b >= 8'h90 && b <= 8'hBF;
          else ok = b >= 8'h80 && b <= 8'hBF;
          if (!ok) begin
            err = ERR_BAD_ENC;
            need_d = '0;
          end else if (need_q == 2'd1) begin
            for (int i = 0; i < 3; i++) job_o.bytes[i] = pend_q[i];
            job_o.bytes[idx[1:0]] = b;
            job_o.count = idx + 3'd1;
            need_d = '0;
          end else begin
            pend_d[idx[1:0]] = b;
            need_d = need_q - 2'd1;
            phase_d = PH_UTF;
          end
        end
      end else if (!mode_i) begin
        case (phase_q)
          PH_ESC: begin
            phase_d = PH_IDLE;
            job_o.count = 3'd1;
            case (b)
              8'h62: job_o.bytes[0] = 8'h08;
              8'h66: job_o.bytes[0] = 8'h0C;
              8'h6E: job_o.bytes[0] = 8'h0A;
              8'h72: job_o.bytes[0] = 8'h0D;
              8'h74: job_o.bytes[0] = 8'h09;
              8'h22, 8'h2F, 8'h5C: job_o.bytes[0] = b;
              8'h75: begin
                job_o.count = 3'd0;
                hex_d = '0;
                phase_d = PH_HEX0;
              end
              default: begin
                job_o.count = 3'd0;
                err = ERR_BAD_ESC;
              end
            endcase
          end
          PH_HEX0, PH_HEX1, PH_HEX2, PH_SHX0, PH_SHX1, PH_SHX2: begin
            if (h[4]) begin
              phase_d = PH_IDLE;
              err = ERR_BAD_ESC;
            end else begin
              hex_d = acc;
              phase_d = phase_e'(phase_q + 4'd1);
            end
          end
          PH_HEX3: begin
            phase_d = PH_IDLE;
            hex_d = acc;
            if (h[4]) err = ERR_BAD_ESC;
            else if (acc >= 16'hDC00 && acc <= 16'hDFFF) err = ERR_BAD_SURR;
            else if (acc >= 16'hD800) begin
              if (acc < 16'hDC00) begin
                high_d = acc[9:0];
                phase_d = PH_SBS;
              end else emit_cp = 1'b1;
            end else emit_cp = 1'b1;
          end
          PH_SHX3: begin
            phase_d = PH_IDLE;
            hex_d = acc;
            if (h[4]) err = ERR_BAD_ESC;
            else if (acc < 16'hDC00 || acc > 16'hDFFF) err = ERR_BAD_SURR;
            else begin
              cp = 21'h10000 + {1'b0, high_q, acc[9:0]};
              emit_cp = 1'b1;
            end
          end
          PH_SBS: begin
            if (b != 8'h5C) begin
              phase_d = PH_IDLE;
              err = ERR_BAD_SURR;
            end else phase_d = PH_SU;
          end
          PH_SU: begin
            if (b != 8'h75) begin
              phase_d = PH_IDLE;
              err = ERR_BAD_SURR;
            end else begin
              hex_d = '0;
              phase_d = PH_SHX0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            if (b < 8'h20 || b == 8'h7F) err = ERR_CTRL;
            else if (b == 8'h5C) phase_d = PH_ESC;
            else if (b < 8'h80) begin
              job_o.bytes[0] = b;
              job_o.count = 3'd1;
            end else if (lead_len(b) < 3'd2) err = ERR_BAD_ENC;
            else begin
              pend_d[0] = b;
              need_d = 2'(lead_len(b) - 3'd1);
              phase_d = PH_UTF;
            end
          end
        endcase
        if (emit_cp) begin
          if (cp < 21'h80) begin
            job_o.bytes[0] = cp[7:0];
            job_o.count = 3'd1;
          end else if (cp < 21'h800) begin
            job_o.bytes[0] = {3'b110, cp[10:6]};
            job_o.bytes[1] = {2'b10, cp[5:0]};
            job_o.count = 3'd2;
          end else if (cp < 21'h10000) begin
            job_o.bytes[0] = {4'b1110, cp[15:12]};
            job_o.bytes[1] = {2'b10, cp[11:6]};
            job_o.bytes[2] = {2'b10, cp[5:0]};
            job_o.count = 3'd3;
          end else begin
            job_o.bytes[0] = {5'b11110, cp[20:18]};
            job_o.bytes[1] = {2'b10, cp[17:12]};
            job_o.bytes[2] = {2'b10, cp[11:6]};
            job_o.bytes[3] = {2'b10, cp[5:0]};
            job_o.count = 3'd4;
          end
        end
      end else begin
        phase_d = PH_IDLE;
        job_o.bytes[0] = 8'h5C;
        job_o.count = 3'd2;
        case (b)
          8'h22: job_o.bytes[1] = 8'h22;
          8'h5C: job_o.bytes[1] = 8'h5C;
          8'h08: job_o.bytes[1] = 8'h62;
          8'h0C: job_o.bytes[1] = 8'h66;
          8'h0A: job_o.bytes[1] = 8'h6E;
          8'h0D: job_o.bytes[1] = 8'h72;
          8'h09: job_o.bytes[1] = 8'h74;
          default: begin
            job_o.count = 3'd0;
            if (b < 8'h20 || b == 8'h7F) err = ERR_BAD_ENC;
            else if (b < 8'h80) begin
              job_o.bytes[0] = b;
              job_o.count = 3'd1;
            end else if (lead_len(b) < 3'd2) err = ERR_BAD_ENC;
            else begin
              pend_d[0] = b;
              need_d = 2'(lead_len(b) - 3'd1);
              phase_d = PH_UTF;
            end
          end
        endcase
      end

      if (err == ERR_NONE && in_i.in_last && phase_d != PH_IDLE) err = ERR_TRUNC;
      if (err != ERR_NONE) begin
        job_o.count = 3'd1;
        job_o.bytes = '0;
        job_o.error = err;
        phase_d = PH_IDLE;
        hex_d = '0;
        high_d = '0;
        need_d = '0;
        drop_d = !in_i.in_last;
      end else if (in_i.in_last) begin
        phase_d = PH_IDLE;
        hex_d = '0;
        high_d = '0;
        need_d = '0;
      end
      job_push_o = job_o.count != 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q <= '0;
      high_q <= '0;
      need_q <= '0;
      drop_q <= 1'b0;
    end else if (clear_i) begin
      phase_q <= PH_IDLE;
      hex_q <= '0;
      high_q <= '0;
      need_q <= '0;
      drop_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hex_q <= hex_d;
      high_q <= high_d;
      need_q <= need_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

[rtl/jsc_queue.sv]
// Job queue between the front end and the output sequencer.
module jsc_queue import jsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t wr_i,
  input  logic push_i,
  output logic full_o,
  output job_t rd_o,
  output logic empty_o,
  input  logic pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rd_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

[rtl/jsc_back.sv]
// Back end: steps through the bytes of each job into a registered output.
module jsc_back import jsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  output out_word_t out_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  logic [1:0] sel_q;
  logic       ov_q;
  out_word_t  out_q;
  logic       load, fin;

  assign load = job_valid_i && (!ov_q || !out_stall_i);
  assign fin  = {1'b0, sel_q} + 3'd1 == job_i.count;
  assign job_pop_o = load && fin;
  assign out_o = out_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        sel_q <= fin ? 2'd0 : sel_q + 2'd1;
      end else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= job_i.bytes[sel_q];
      out_q.run_last <= fin;
      out_q.string_end <= fin && job_i.last;
      out_q.error <= job_i.error;
    end
  end

endmodule

[rtl/json_string_codec_unit.sv]
// Top level of the streaming JSON string escape/unescape codec.
// Takes one string byte per cycle while its job queue has room; each byte yields
// zero to four result words, delivered one per cycle by the output sequencer while
// the receiver does not stall. Mode writes clear the stream state and should only
// be made while the block is idle.
module json_string_codec_unit import jsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output out_word_t out_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic mode_q, full, empty, push, pop, fire, cfg_fire;
  job_t job, head;

  assign in_stall_o = full;
  assign fire = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_fire) mode_q <= cfg_data_i;
  end

  jsc_front u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .clear_i(cfg_fire), .in_i,
    .in_fire_i(fire), .job_o(job), .job_push_o(push)
  );

  jsc_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni, .wr_i(job), .push_i(push), .full_o(full),
    .rd_o(head), .empty_o(empty), .pop_i(pop)
  );

  jsc_back u_back (
    .clk_i, .rst_ni, .job_i(head), .job_valid_i(!empty), .job_pop_o(pop),
    .out_o, .out_valid_o, .out_stall_i
  );

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.error != ERR_NONE |-> out_o.run_last && out_o.out_byte == 8'h00)
    else $error("error word not single");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("queue overflow");
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.string_end |-> out_o.run_last)
    else $error("string end without run end");
`endif

endmodule

[dv/json_string_codec_unit_tb.sv]
// Self-checking testbench for the streaming JSON string codec unit.
module json_string_codec_unit_tb;
  import jsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBytes = 36;

  logic      clk;
  logic      rst_n;
  in_word_t  in_word;
  logic      in_valid;
  logic      in_stall;
  out_word_t out_word;
  logic      out_valid;
  logic      out_stall;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  json_string_codec_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_word),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_o      (out_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // Codec state kept by the predictor.
  logic       cur_mode;
  phase_e     cur_phase;
  logic [15:0] acc;
  logic [9:0] hi_half;
  logic [7:0] held [3];
  logic [1:0] need;
  logic       drop;

  in_word_t  send_q [$];
  out_word_t expected_q [$];
  int        mismatch_cnt;
  int        idle_cycles;
  logic      hold_off;
  int        hold_len;
  logic      sender_pause;

  function automatic int unsigned nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return 16;
  endfunction

  function automatic int unsigned seq_len(input logic [7:0] b);
    if (b < 8'h80) return 1;
    if (b < 8'hC0) return 0;
    if (b < 8'hE0) return 2;
    if (b < 8'hF0) return 3;
    if (b < 8'hF5) return 4;
    return 0;
  endfunction

  task automatic clear_codec();
    cur_phase = PH_IDLE;
    acc = '0;
    hi_half = '0;
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
    need = '0;
    drop = 1'b0;
  endtask

  task automatic emit_cp(input logic [31:0] cp, inout logic [7:0] bs [$]);
    if (cp < 32'h80) begin
      bs.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      bs.push_back(8'((cp >> 6) | 8'hC0));
      bs.push_back(8'((cp & 8'h3F) | 8'h80));
    end else if (cp < 32'h10000) begin
      bs.push_back(8'((cp >> 12) | 8'hE0));
      bs.push_back(8'(((cp >> 6) & 8'h3F) | 8'h80));
      bs.push_back(8'((cp & 8'h3F) | 8'h80));
    end else begin
      bs.push_back(8'(((cp >> 18) & 8'h07) | 8'hF0));
      bs.push_back(8'(((cp >> 12) & 8'h3F) | 8'h80));
      bs.push_back(8'(((cp >> 6) & 8'h3F) | 8'h80));
      bs.push_back(8'((cp & 8'h3F) | 8'h80));
    end
  endtask

  function automatic err_e start_seq(input logic [7:0] b);
    int unsigned len;
    len = seq_len(b);
    if (len < 2) return ERR_BAD_ENC;
    held[0] = b;
    need = 2'(len - 1);
    cur_phase = PH_UTF;
    return ERR_NONE;
  endfunction

  task automatic codec_step(input in_word_t w);
    logic [7:0] b;
    logic [7:0] bs [$];
    err_e code;
    int unsigned h, len, idx;
    logic [31:0] cp;
    logic ok, second;
    out_word_t r;
    b = w.in_byte;
    code = ERR_NONE;
    if (drop) begin
      if (w.in_last) clear_codec();
      return;
    end
    if (cur_phase == PH_UTF) begin
      len = seq_len(held[0]);
      idx = len - need;
      cur_phase = PH_IDLE;
      if (idx == 1 && held[0] == 8'hE0) ok = b >= 8'hA0 && b <= 8'hBF;
      else if (idx == 1 && held[0] == 8'hF0) ok = b >= 8'h90 && b <= 8'hBF;
      else ok = b >= 8'h80 && b <= 8'hBF;
      if (!ok) begin
        need = '0;
        code = ERR_BAD_ENC;
      end else if (need == 2'd1) begin
        for (int i = 0; i < idx; i++) bs.push_back(held[i]);
        bs.push_back(b);
        need = '0;
      end else begin
        held[idx] = b;
        need = need - 2'd1;
        cur_phase = PH_UTF;
      end
    end else if (cur_mode == 1'b0) begin
      h = nibble(b);
      if (cur_phase == PH_ESC) begin
        cur_phase = PH_IDLE;
        case (b)
          "b": bs.push_back(8'h08);
          "f": bs.push_back(8'h0C);
          "n": bs.push_back(8'h0A);
          "r": bs.push_back(8'h0D);
          "t": bs.push_back(8'h09);
          "\"", "/", "\\": bs.push_back(b);
          "u": begin
            acc = '0;
            cur_phase = PH_HEX0;
          end
          default: code = ERR_BAD_ESC;
        endcase
      end else if ((cur_phase >= PH_HEX0 && cur_phase <= PH_HEX3) ||
                   (cur_phase >= PH_SHX0 && cur_phase <= PH_SHX3)) begin
        second = cur_phase >= PH_SHX0;
        if (h > 15) begin
          cur_phase = PH_IDLE;
          code = ERR_BAD_ESC;
        end else begin
          acc = {acc[11:0], 4'(h)};
          if (cur_phase != PH_HEX3 && cur_phase != PH_SHX3) begin
            cur_phase = phase_e'(cur_phase + 4'd1);
          end else begin
            cur_phase = PH_IDLE;
            cp = {16'd0, acc};
            if (second) begin
              if (cp < 32'hDC00 || cp > 32'hDFFF) code = ERR_BAD_SURR;
              else emit_cp(32'h10000 + ({22'd0, hi_half} << 10) + (cp - 32'hDC00), bs);
            end else if (cp >= 32'hDC00 && cp <= 32'hDFFF) begin
              code = ERR_BAD_SURR;
            end else if (cp >= 32'hD800 && cp < 32'hDC00) begin
              hi_half = 10'(cp - 32'hD800);
              cur_phase = PH_SBS;
            end else begin
              emit_cp(cp, bs);
            end
          end
        end
      end else if (cur_phase == PH_SBS) begin
        if (b != "\\") begin
          cur_phase = PH_IDLE;
          code = ERR_BAD_SURR;
        end else cur_phase = PH_SU;
      end else if (cur_phase == PH_SU) begin
        if (b != "u") begin
          cur_phase = PH_IDLE;
          code = ERR_BAD_SURR;
        end else begin
          acc = '0;
          cur_phase = PH_SHX0;
        end
      end else begin
        cur_phase = PH_IDLE;
        if (b < 8'h20 || b == 8'h7F) code = ERR_CTRL;
        else if (b == "\\") cur_phase = PH_ESC;
        else if (b < 8'h80) bs.push_back(b);
        else code = start_seq(b);
      end
    end else begin
      cur_phase = PH_IDLE;
      case (b)
        "\"", "\\": begin bs.push_back("\\"); bs.push_back(b); end
        8'h08: begin bs.push_back("\\"); bs.push_back("b"); end
        8'h0C: begin bs.push_back("\\"); bs.push_back("f"); end
        8'h0A: begin bs.push_back("\\"); bs.push_back("n"); end
        8'h0D: begin bs.push_back("\\"); bs.push_back("r"); end
        8'h09: begin bs.push_back("\\"); bs.push_back("t"); end
        default: begin
          if (b < 8'h20 || b == 8'h7F) code = ERR_BAD_ENC;
          else if (b < 8'h80) bs.push_back(b);
          else code = start_seq(b);
        end
      endcase
    end
    if (code == ERR_NONE && w.in_last && cur_phase != PH_IDLE) code = ERR_TRUNC;
    if (code != ERR_NONE) begin
      r.out_byte = '0;
      r.run_last = 1'b1;
      r.string_end = w.in_last;
      r.error = code;
      expected_q.push_back(r);
      clear_codec();
      if (!w.in_last) drop = 1'b1;
      return;
    end
    foreach (bs[i]) begin
      r.out_byte = bs[i];
      r.run_last = (i == bs.size() - 1);
      r.string_end = r.run_last && w.in_last;
      r.error = ERR_NONE;
      expected_q.push_back(r);
    end
    if (w.in_last) clear_codec();
  endtask

  task automatic report_mismatch(input string what, input out_word_t got, input out_word_t exp);
    $display("mismatch %s: got %h/%0b/%0b/%0d exp %h/%0b/%0b/%0d", what, got.out_byte,
             got.run_last, got.string_end, got.error, exp.out_byte, exp.run_last,
             exp.string_end, exp.error);
    mismatch_cnt++;
  endtask

  task automatic queue_str(input string s, input logic last_on_end);
    in_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.in_byte = s[i];
      w.in_last = last_on_end && (i == s.len() - 1);
      send_q.push_back(w);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic l);
    in_word_t w;
    w.in_byte = b;
    w.in_last = l;
    send_q.push_back(w);
  endtask

  function automatic string hex4(input logic [15:0] v);
    return $sformatf("%04h", v);
  endfunction

  // Random string body: mostly well-formed pieces, some noise.
  task automatic queue_random_string(input logic m);
    int pieces;
    logic [7:0] c;
    string s;
    string esc_set;
    esc_set = "bfnrt\"/\\";
    pieces = $urandom_range(1, 6);
    s = "";
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1: s = {s, string'(8'($urandom_range(8'h20, 8'h7E)))};
        2: begin
          if (m) s = {s, string'(8'($urandom_range(0, 8'h1F)))};
          else begin
            c = esc_set[$urandom_range(0, 7)];
            s = {s, "\\", string'(c)};
          end
        end
        3: s = {s, "\\u", hex4(16'($urandom_range(0, 16'hD7FF)))};
        4: s = {s, "\\u", hex4(16'($urandom_range(16'hD800, 16'hDBFF))),
                "\\u", hex4(16'($urandom_range(16'hDC00, 16'hDFFF)))};
        5: s = {s, string'(8'($urandom_range(8'hC2, 8'hDF))),
                string'(8'($urandom_range(8'h80, 8'hBF)))};
        6: s = {s, string'(8'($urandom_range(8'hE0, 8'hEF))),
                string'(8'($urandom_range(8'hA0, 8'hBF))),
                string'(8'($urandom_range(8'h80, 8'hBF)))};
        7: s = {s, string'(8'($urandom_range(8'hF0, 8'hF4))),
                string'(8'($urandom_range(8'h90, 8'hBF))),
                string'(8'($urandom_range(8'h80, 8'hBF))),
                string'(8'($urandom_range(8'h80, 8'hBF)))};
        8: s = {s, "\\u", hex4(16'($urandom))};
        default: s = {s, string'(8'($urandom_range(1, 255)))};
      endcase
    end
    queue_str(s, 1'b1);
    // a zero byte cannot live in a string literal, so mix raw noise separately
    if ($urandom_range(0, 5) == 0) queue_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: bursts with random gaps.
  int burst_left, gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        codec_step(in_word);
        void'(send_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (sender_pause || send_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word <= send_q[0];
        if (burst_left == 0) burst_left = $urandom_range(1, 30);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase = 0;
      idle_cycles = 0;
      hold_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected", out_word, '0);
        end else if (out_word != expected_q[0]) begin
          report_mismatch("field", out_word, expected_q[0]);
          void'(expected_q.pop_front());
        end else void'(expected_q.pop_front());
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (hold_off) begin
        out_stall <= 1'b1;
        hold_len++;
      end else begin
        stall_phase = (stall_phase + 1) % 23;
        out_stall <= (stall_phase < 12) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
      if (idle_cycles >= IdleLimit) begin
        $display("json_string_codec_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_mode(input logic m);
    while (send_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mode = m;
    clear_codec();
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    hold_off = 1'b0;
    sender_pause = 1'b0;
    mismatch_cnt = 0;
    cur_mode = 1'b0;
    clear_codec();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decode directed: escapes, \u forms, surrogates, errors, truncation.
    write_mode(1'b0);
    queue_str("a\\b\\f\\n\\r\\t\\\"\\/\\\\\"", 1'b1);
    queue_str("\\u0000\\u007F\\u07FF\\uFFFF\\uD83D\\uDE00", 1'b1);
    queue_byte(8'h1F, 1'b0); queue_str("xx", 1'b1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_str("\\q", 1'b1);
    queue_str("\\u12G4", 1'b1);
    queue_str("\\uDC00", 1'b1);
    queue_str("\\uD800x", 1'b1);
    queue_str("\\uD800\\x", 1'b1);
    queue_str("\\uD800\\u0041", 1'b1);
    queue_str("\\u12", 1'b1);
    queue_byte(8'hE0, 1'b0); queue_byte(8'h9F, 1'b1);
    queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b1);
    queue_byte(8'hC3, 1'b1);
    wait_drained();

    // Long receiver hold-off so the input backs up.
    for (int i = 0; i < 8; i++) queue_str("\\uD83D\\uDE00", 1'b1);
    hold_off = 1'b1;
    while (hold_len < 300) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();

    // Sender pause until all results are in.
    sender_pause = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    sender_pause = 1'b0;

    // Encode directed.
    write_mode(1'b1);
    queue_str("\"\\ok", 1'b0);
    queue_byte(8'h08, 1'b0); queue_byte(8'h0C, 1'b0); queue_byte(8'h0A, 1'b0);
    queue_byte(8'h0D, 1'b0); queue_byte(8'h09, 1'b0);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h80, 1'b1);
    wait_drained();

    // Random phases across both modes, ending on each.
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(1'(ph % 2));
      for (int k = 0; k < PhaseBytes; k++) begin
        if ($urandom_range(0, 7) == 0) queue_byte(8'($urandom), 1'($urandom));
        else queue_random_string(cur_mode);
        if (send_q.size() > PhaseBytes) break;
      end
      wait_drained();
    end

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("json_string_codec_unit_tb: PASS");
    end else begin
      $display("json_string_codec_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[json_string_codec_unit.f]
rtl/jsc_pkg.sv
rtl/jsc_front.sv
rtl/jsc_queue.sv
rtl/jsc_back.sv
rtl/json_string_codec_unit.sv
dv/json_string_codec_unit_tb.sv
